// File: sv/bda_pkg.sv
package bda_pkg;

  localparam int NUM_BITS   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = $clog2(NUM_BITS);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam logic [5:0] ASCII_NINE = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  // control shared by every digit cell of the row
  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctrl_t;

endpackage

// File: sv/bda_num_if.sv
interface bda_num_if;
  logic        valid;
  logic        ready;
  logic [31:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// File: sv/bda_dig_if.sv
interface bda_dig_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: sv/bda_cell.sv
module bda_cell (
  input  logic               clk,
  input  bda_pkg::cell_ctrl_t ctrl,
  input  logic               bit_in,
  input  logic [3:0]         digit_in,
  output logic               bit_out,
  output logic [3:0]         digit
);

  logic [3:0] adj;

  // add-3 correction before the doubling shift
  assign adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.shift_bit) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.shift_digit) begin
      digit <= digit_in;
    end
  end

endmodule

// File: sv/binary_to_decimal_ascii.sv
// Converts one 32-bit unsigned number per request into its decimal digits as ASCII
// codes, most significant first, with leading zeros dropped and the final digit
// flagged by last_digit. A number is taken only while the block is idle. The
// conversion runs through a row of ten BCD digit cells, one input bit per cycle;
// then the row shifts one digit per cycle toward the output, skipping each leading
// zero (up to nine) without waiting and delivering each digit only while the
// output side is ready, so a stalled output holds the row.
module binary_to_decimal_ascii (
  input  logic             clk,
  input  logic             rst,
  bda_num_if.sink          numbers,
  bda_dig_if.source        digits
);

  localparam int TOP = bda_pkg::NUM_DIGITS - 1;

  bda_pkg::state_t                  state, state_next;
  bda_pkg::cell_ctrl_t              ctrl;
  logic [bda_pkg::NUM_BITS-1:0]     bin;
  logic [bda_pkg::CNT_W-1:0]        cnt;
  logic [bda_pkg::REM_W-1:0]        rem;
  logic                             started;
  logic                             lead_zero;
  logic                             cnt_done;
  logic                             out_fire;

  logic [3:0] digit     [bda_pkg::NUM_DIGITS];
  logic       carry     [bda_pkg::NUM_DIGITS];

  for (genvar i = 0; i < bda_pkg::NUM_DIGITS; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;

    if (i == 0) begin : g_first
      assign bit_in   = bin[bda_pkg::NUM_BITS-1];
      assign digit_in = 4'd0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end

    bda_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bit_in),
      .digit_in (digit_in),
      .bit_out  (carry[i]),
      .digit    (digit[i])
    );
  end

  assign cnt_done  = (cnt == bda_pkg::CNT_W'(bda_pkg::NUM_BITS - 1));
  assign lead_zero = (digit[TOP] == 4'd0) && !started && (rem != bda_pkg::REM_W'(1));
  assign out_fire  = digits.valid && digits.ready;

  assign digits.digit_char = bda_pkg::ASCII_ZERO + {2'b00, digit[TOP]};
  assign digits.last_digit = (rem == bda_pkg::REM_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bda_pkg::ST_IDLE: begin
        if (numbers.valid) state_next = bda_pkg::ST_CONVERT;
      end
      bda_pkg::ST_CONVERT: begin
        if (cnt_done) state_next = bda_pkg::ST_EMIT;
      end
      bda_pkg::ST_EMIT: begin
        if (out_fire && digits.last_digit) state_next = bda_pkg::ST_IDLE;
      end
      default: state_next = bda_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    numbers.ready    = 1'b0;
    digits.valid     = 1'b0;
    ctrl.clear       = 1'b0;
    ctrl.shift_bit   = 1'b0;
    ctrl.shift_digit = 1'b0;
    unique case (state)
      bda_pkg::ST_IDLE: begin
        numbers.ready = 1'b1;
        ctrl.clear    = numbers.valid;
      end
      bda_pkg::ST_CONVERT: begin
        ctrl.shift_bit = 1'b1;
      end
      bda_pkg::ST_EMIT: begin
        digits.valid     = !lead_zero;
        ctrl.shift_digit = lead_zero || digits.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bda_pkg::ST_IDLE;
      cnt     <= '0;
      rem     <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        bda_pkg::ST_IDLE: begin
          cnt <= '0;
        end
        bda_pkg::ST_CONVERT: begin
          cnt     <= cnt + 1'b1;
          rem     <= bda_pkg::REM_W'(bda_pkg::NUM_DIGITS);
          started <= 1'b0;
        end
        bda_pkg::ST_EMIT: begin
          if (out_fire) begin
            rem     <= rem - 1'b1;
            started <= 1'b1;
          end else if (lead_zero) begin
            rem <= rem - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // binary word feeding the cell row, msb first
  always_ff @(posedge clk) begin
    if (state == bda_pkg::ST_IDLE && numbers.valid) begin
      bin <= numbers.number;
    end else if (state == bda_pkg::ST_CONVERT) begin
      bin <= {bin[bda_pkg::NUM_BITS-2:0], 1'b0};
    end
  end

  // ten digits always hold a 32-bit value, so the top cell never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    state == bda_pkg::ST_CONVERT |-> !carry[TOP])
    else $error("top digit cell overflowed");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digits.valid |-> (digits.digit_char >= bda_pkg::ASCII_ZERO &&
                      digits.digit_char <= bda_pkg::ASCII_NINE))
    else $error("digit outside ascii range");

  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    numbers.valid && numbers.ready |=> state == bda_pkg::ST_CONVERT)
    else $error("request did not start conversion");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_fire && digits.last_digit |=> state == bda_pkg::ST_IDLE && numbers.ready)
    else $error("run did not end after last digit");

endmodule
